FILE: src/iatirq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interface adapter package
// Shared codes and the command and status types between controller and datapath.
// ----------------------------------------------------------------------------
package iatirq_pkg;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [3:0] REG_ORB  = 4'd0;
  localparam logic [3:0] REG_ORA  = 4'd1;
  localparam logic [3:0] REG_T1CL = 4'd4;
  localparam logic [3:0] REG_T1CH = 4'd5;
  localparam logic [3:0] REG_T1LL = 4'd6;
  localparam logic [3:0] REG_T1LH = 4'd7;
  localparam logic [3:0] REG_T2CL = 4'd8;
  localparam logic [3:0] REG_T2CH = 4'd9;
  localparam logic [3:0] REG_SR   = 4'd10;
  localparam logic [3:0] REG_ACR  = 4'd11;
  localparam logic [3:0] REG_PCR  = 4'd12;
  localparam logic [3:0] REG_IFR  = 4'd13;
  localparam logic [3:0] REG_IER  = 4'd14;
  localparam logic [3:0] REG_ORAN = 4'd15;

  localparam int unsigned RF_DEPTH = 15;

  typedef struct packed {
    logic load;
    logic step;
  } iatirq_cmd_t;

  typedef struct packed {
    logic last;
  } iatirq_sts_t;

endpackage

FILE: src/interface_adapter_timers_irq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interface adapter with timers and interrupt logic
// Register file, two down-counters and interrupt flags of a 6522-style adapter.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state and carried out in the run state, where its
// result is registered and presented, held back while an older result stalls. A tick
// walks the timer1 loop pass by pass: a pass per underflow, a pass per reload from the
// minus-one state and a pass for the final count. No new request is taken until done.
// Synchronous reset clears registers, timers and flags; the PB7 toggle resets to one.
module interface_adapter_timers_irq_core #(
  parameter int unsigned MAX_TICK_CLOCKS = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [3:0] in_reg_index,
  input  logic [7:0] in_write_data,
  input  logic       in_peek,
  input  logic [7:0] in_clocks,
  input  logic [7:0] in_pb6_pulses,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic       out_pb7_level
);

  iatirq_pkg::iatirq_cmd_t cmd;
  iatirq_pkg::iatirq_sts_t sts;

  iatirq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  iatirq_dp #(
    .MAX_TICK_CLOCKS (MAX_TICK_CLOCKS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_action),
    .in_reg_index  (in_reg_index),
    .in_write_data (in_write_data),
    .in_peek       (in_peek),
    .in_clocks     (in_clocks),
    .in_pb6_pulses (in_pb6_pulses),
    .out_read_data (out_read_data),
    .out_irq       (out_irq),
    .out_pb7_level (out_pb7_level)
  );

endmodule

FILE: src/iatirq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interface adapter controller
// Accepts a request, steps the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module iatirq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output iatirq_pkg::iatirq_cmd_t cmd,
  input  iatirq_pkg::iatirq_sts_t sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load = (state_r == ST_IDLE) && in_valid;
    cmd.step = (state_r == ST_RUN) && (!sts.last || out_free);
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.step && sts.last) begin
          state_nxt = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/iatirq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interface adapter datapath
// Register file, timers, flags and the iterative timer1 tick unit.
// ----------------------------------------------------------------------------
module iatirq_dp #(
  parameter int unsigned MAX_TICK_CLOCKS = 255
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iatirq_pkg::iatirq_cmd_t cmd,
  output iatirq_pkg::iatirq_sts_t sts,
  input  logic [1:0]              in_action,
  input  logic [3:0]              in_reg_index,
  input  logic [7:0]              in_write_data,
  input  logic                    in_peek,
  input  logic [7:0]              in_clocks,
  input  logic [7:0]              in_pb6_pulses,
  output logic [7:0]              out_read_data,
  output logic                    out_irq,
  output logic                    out_pb7_level
);

  logic [7:0]  rf_r [iatirq_pkg::RF_DEPTH];
  logic [7:0]  rf_nxt [iatirq_pkg::RF_DEPTH];
  logic [15:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic        m1_r, m1_nxt, act1_r, act1_nxt, act2_r, act2_nxt, tog_r, tog_nxt;
  logic [1:0]  action_r;
  logic [3:0]  idx_r;
  logic [7:0]  wd_r;
  logic        peek_r;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        irq_r, pb7_r;
  logic [7:0]  clk_sat, t2n, ifr, pcr;
  logic [15:0] latch;
  logic [16:0] lp1, used17;
  logic [17:0] sum2, used18;
  logic [15:0] left16;
  logic [7:0]  tick_left;
  logic        last;

  always_comb begin
    for (int i = 0; i < iatirq_pkg::RF_DEPTH; i++) begin
      rf_nxt[i] = rf_r[i];
    end
    t1_nxt = t1_r;
    t2_nxt = t2_r;
    m1_nxt = m1_r;
    act1_nxt = act1_r;
    act2_nxt = act2_r;
    tog_nxt = tog_r;
    left_nxt = left_r;
    rd_nxt = 8'd0;
    ifr = rf_r[iatirq_pkg::REG_IFR];
    pcr = rf_r[iatirq_pkg::REG_PCR];
    latch = {rf_r[iatirq_pkg::REG_T1LH], rf_r[iatirq_pkg::REG_T1LL]};
    lp1 = {1'b0, latch} + 17'd1;
    sum2 = {2'b00, t1_r} + {2'b00, latch} + 18'd2;
    left16 = {8'd0, left_r};
    used17 = ({1'b0, left16} < lp1) ? {1'b0, left16} : lp1;
    used18 = ({2'b00, left16} < sum2) ? {2'b00, left16} : sum2;
    if (m1_r) begin
      tick_left = left_r - used17[7:0];
    end else if (t1_r < left16) begin
      tick_left = (left16 - t1_r == 16'd1) ? left_r - 8'd1 : left_r - used18[7:0];
    end else begin
      tick_left = 8'd0;
    end
    last = (action_r != iatirq_pkg::ACT_TICK) || (left_r == 8'd0) || (tick_left == 8'd0);
    clk_sat = ({8'd0, in_clocks} > 16'(MAX_TICK_CLOCKS)) ? 8'(MAX_TICK_CLOCKS) : in_clocks;
    t2n = rf_r[iatirq_pkg::REG_ACR][5] ? in_pb6_pulses : clk_sat;
    if (cmd.load) begin
      left_nxt = clk_sat;
      if (in_action == iatirq_pkg::ACT_TICK) begin
        if (t2_r < {8'd0, t2n} && act2_r) begin
          ifr = ifr | 8'h20;
          act2_nxt = 1'b0;
        end
        t2_nxt = t2_r - {8'd0, t2n};
      end
    end else if (cmd.step) begin
      case (action_r)
        iatirq_pkg::ACT_READ: begin
          case (idx_r)
            iatirq_pkg::REG_ORB: begin
              rd_nxt = rf_r[iatirq_pkg::REG_ORB];
              if (!peek_r) begin
                ifr = ifr & 8'hEF;
                if ((pcr & 8'hA0) != 8'h20) ifr = ifr & 8'hF7;
              end
            end
            iatirq_pkg::REG_ORA, iatirq_pkg::REG_ORAN: begin
              rd_nxt = rf_r[iatirq_pkg::REG_ORA];
              if (!peek_r) begin
                ifr = ifr & 8'hFD;
                if ((pcr & 8'h0A) != 8'h02) ifr = ifr & 8'hFE;
              end
            end
            iatirq_pkg::REG_T1CL: begin
              rd_nxt = t1_r[7:0];
              if (!peek_r) ifr = ifr & 8'hBF;
            end
            iatirq_pkg::REG_T1CH: rd_nxt = t1_r[15:8];
            iatirq_pkg::REG_T2CL: begin
              rd_nxt = t2_r[7:0];
              if (!peek_r) ifr = ifr & 8'hDF;
            end
            iatirq_pkg::REG_T2CH: rd_nxt = t2_r[15:8];
            iatirq_pkg::REG_SR: begin
              rd_nxt = rf_r[iatirq_pkg::REG_SR];
              if (!peek_r) ifr = ifr & 8'hFB;
            end
            iatirq_pkg::REG_IFR: begin
              rd_nxt = ifr | (((ifr & rf_r[iatirq_pkg::REG_IER]) != 8'd0) ? 8'h80 : 8'h00);
            end
            iatirq_pkg::REG_IER: rd_nxt = rf_r[iatirq_pkg::REG_IER] | 8'h80;
            default: rd_nxt = rf_r[idx_r];
          endcase
        end
        iatirq_pkg::ACT_WRITE: begin
          case (idx_r)
            iatirq_pkg::REG_ORB: begin
              ifr = ifr & 8'hEF;
              if ((pcr & 8'hA0) != 8'h20) ifr = ifr & 8'hF7;
              rf_nxt[iatirq_pkg::REG_ORB] = wd_r;
            end
            iatirq_pkg::REG_ORA, iatirq_pkg::REG_ORAN: begin
              ifr = ifr & 8'hFD;
              if ((pcr & 8'h0A) != 8'h02) ifr = ifr & 8'hFE;
              rf_nxt[iatirq_pkg::REG_ORA] = wd_r;
            end
            iatirq_pkg::REG_T1CL: rf_nxt[iatirq_pkg::REG_T1LL] = wd_r;
            iatirq_pkg::REG_T1CH, iatirq_pkg::REG_T1LH: begin
              ifr = ifr & 8'hBF;
              rf_nxt[iatirq_pkg::REG_T1LH] = wd_r;
              if (idx_r == iatirq_pkg::REG_T1CH) begin
                t1_nxt = {wd_r, rf_r[iatirq_pkg::REG_T1LL]};
                act1_nxt = 1'b1;
                tog_nxt = 1'b0;
              end
            end
            iatirq_pkg::REG_T2CH: begin
              ifr = ifr & 8'hDF;
              t2_nxt = {wd_r, rf_r[iatirq_pkg::REG_T2CL]};
              act2_nxt = 1'b1;
            end
            iatirq_pkg::REG_SR: begin
              ifr = ifr & 8'hFB;
              rf_nxt[iatirq_pkg::REG_SR] = wd_r;
            end
            iatirq_pkg::REG_IFR: begin
              if (wd_r[0] && (pcr & 8'h0A) == 8'h02) ifr = ifr & 8'hFE;
              if (wd_r[3] && (pcr & 8'hA0) == 8'h20) ifr = ifr & 8'hF7;
            end
            iatirq_pkg::REG_IER: begin
              if (wd_r[7]) begin
                rf_nxt[iatirq_pkg::REG_IER] = rf_r[iatirq_pkg::REG_IER] | {1'b0, wd_r[6:0]};
              end else begin
                rf_nxt[iatirq_pkg::REG_IER] = rf_r[iatirq_pkg::REG_IER] & {1'b0, ~wd_r[6:0]};
              end
            end
            default: rf_nxt[idx_r] = wd_r;
          endcase
        end
        iatirq_pkg::ACT_TICK: begin
          if (left_r != 8'd0) begin
            if (m1_r) begin
              t1_nxt = 16'(lp1 - used17);
              m1_nxt = 1'b0;
              left_nxt = left_r - used17[7:0];
            end else if (t1_r < left16) begin
              if (act1_r) begin
                ifr = ifr | 8'h40;
                tog_nxt = !tog_r;
                if (!rf_r[iatirq_pkg::REG_ACR][6]) act1_nxt = 1'b0;
              end
              if (left16 - t1_r == 16'd1) begin
                t1_nxt = 16'hFFFF;
                m1_nxt = 1'b1;
                left_nxt = left_r - 8'd1;
              end else begin
                t1_nxt = 16'(sum2 - used18);
                left_nxt = left_r - used18[7:0];
              end
            end else begin
              t1_nxt = t1_r - left16;
              left_nxt = 8'd0;
            end
          end
        end
        default: rd_nxt = 8'd0;
      endcase
    end
    rf_nxt[iatirq_pkg::REG_IFR] = ifr;
  end

  assign sts.last = last;
  assign out_read_data = rd_r;
  assign out_irq = irq_r;
  assign out_pb7_level = pb7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iatirq_pkg::RF_DEPTH; i++) begin
        rf_r[i] <= 8'd0;
      end
      t1_r <= 16'd0;
      t2_r <= 16'd0;
      m1_r <= 1'b0;
      act1_r <= 1'b0;
      act2_r <= 1'b0;
      tog_r <= 1'b1;
      left_r <= 8'd0;
    end else begin
      for (int i = 0; i < iatirq_pkg::RF_DEPTH; i++) begin
        rf_r[i] <= rf_nxt[i];
      end
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      m1_r <= m1_nxt;
      act1_r <= act1_nxt;
      act2_r <= act2_nxt;
      tog_r <= tog_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      idx_r <= in_reg_index;
      wd_r <= in_write_data;
      peek_r <= in_peek;
    end
    if (cmd.step && last) begin
      rd_r <= rd_nxt;
      irq_r <= (rf_nxt[iatirq_pkg::REG_IFR] & rf_nxt[iatirq_pkg::REG_IER]) != 8'd0;
      pb7_r <= tog_nxt;
    end
  end

endmodule

FILE: src/iatirq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interface adapter port checker
// Checks request sequencing and result stability seen at the ports.
// ----------------------------------------------------------------------------
module iatirq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_irq,
  input logic       out_pb7_level
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in progress");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("handshake not idle after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_irq))
    else $error("stalled result changed");

  a_result_update: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid) && !$stable(out_pb7_level) |-> out_valid)
    else $error("result changed without being presented");

endmodule

bind interface_adapter_timers_irq_core iatirq_checker u_iatirq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data),
  .out_irq       (out_irq),
  .out_pb7_level (out_pb7_level)
);

FILE: tb/sv/interface_adapter_timers_irq_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interface adapter core testbench
// Drives bus reads, bus writes and timer ticks into the adapter and checks the
// read byte, the IRQ level and the PB7 level of every response against a
// behavioural model of the register file, flags and timers kept alongside.
// ----------------------------------------------------------------------------
module interface_adapter_timers_irq_core_test;

  localparam int unsigned TICK_LIMIT = 255;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] regn;
    logic [7:0] wdata;
    logic       peek;
    logic [7:0] clocks;
    logic [7:0] pulses;
  } request_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       pb7;
  } response_t;

  typedef struct {
    request_t  req;
    logic      known;
    response_t rsp;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_action;
  logic [3:0] in_reg_index;
  logic [7:0] in_write_data;
  logic       in_peek;
  logic [7:0] in_clocks;
  logic [7:0] in_pb6_pulses;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_data;
  logic       out_irq;
  logic       out_pb7_level;

  interface_adapter_timers_irq_core #(.MAX_TICK_CLOCKS(TICK_LIMIT)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_reg_index(in_reg_index),
    .in_write_data(in_write_data), .in_peek(in_peek),
    .in_clocks(in_clocks), .in_pb6_pulses(in_pb6_pulses),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_data(out_read_data), .out_irq(out_irq),
    .out_pb7_level(out_pb7_level)
  );

  logic [7:0]  model_regs [0:14];
  logic [15:0] t1_count;
  logic [15:0] t2_count;
  logic        t1_reload_due;
  logic        t1_running;
  logic        t2_running;
  logic        pb7_state;

  response_t expected_responses [$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("interface_adapter_timers_irq_core_test: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  function automatic void model_reset();
    for (int i = 0; i < 15; i++) model_regs[i] = 8'h00;
    t1_count = 16'h0;
    t2_count = 16'h0;
    t1_reload_due = 1'b0;
    t1_running = 1'b0;
    t2_running = 1'b0;
    pb7_state = 1'b1;
  endfunction

  function automatic void clear_port_a();
    model_regs[iatirq_pkg::REG_IFR][1] = 1'b0;
    if ((model_regs[iatirq_pkg::REG_PCR] & 8'h0a) != 8'h02)
      model_regs[iatirq_pkg::REG_IFR][0] = 1'b0;
  endfunction

  function automatic void clear_port_b();
    model_regs[iatirq_pkg::REG_IFR][4] = 1'b0;
    if ((model_regs[iatirq_pkg::REG_PCR] & 8'ha0) != 8'h20)
      model_regs[iatirq_pkg::REG_IFR][3] = 1'b0;
  endfunction

  function automatic logic [7:0] model_read(input logic [3:0] r, input logic pk);
    logic [7:0] v;
    case (r)
      iatirq_pkg::REG_ORB: begin
        if (!pk) clear_port_b();
        v = model_regs[0];
      end
      iatirq_pkg::REG_ORA, iatirq_pkg::REG_ORAN: begin
        if (!pk) clear_port_a();
        v = model_regs[1];
      end
      iatirq_pkg::REG_T1CL: begin
        if (!pk) model_regs[iatirq_pkg::REG_IFR][6] = 1'b0;
        v = t1_count[7:0];
      end
      iatirq_pkg::REG_T1CH: v = t1_count[15:8];
      iatirq_pkg::REG_T2CL: begin
        if (!pk) model_regs[iatirq_pkg::REG_IFR][5] = 1'b0;
        v = t2_count[7:0];
      end
      iatirq_pkg::REG_T2CH: v = t2_count[15:8];
      iatirq_pkg::REG_SR: begin
        if (!pk) model_regs[iatirq_pkg::REG_IFR][2] = 1'b0;
        v = model_regs[iatirq_pkg::REG_SR];
      end
      iatirq_pkg::REG_IFR: v = model_regs[iatirq_pkg::REG_IFR] |
                   (((model_regs[iatirq_pkg::REG_IFR] & model_regs[iatirq_pkg::REG_IER]) != 0)
                    ? 8'h80 : 8'h00);
      iatirq_pkg::REG_IER: v = model_regs[iatirq_pkg::REG_IER] | 8'h80;
      default: v = model_regs[r];
    endcase
    return v;
  endfunction

  function automatic void model_write(input logic [3:0] r, input logic [7:0] v);
    logic [7:0] pcr;
    pcr = model_regs[iatirq_pkg::REG_PCR];
    case (r)
      iatirq_pkg::REG_ORB: begin
        clear_port_b();
        model_regs[0] = v;
      end
      iatirq_pkg::REG_ORA, iatirq_pkg::REG_ORAN: begin
        clear_port_a();
        model_regs[1] = v;
      end
      iatirq_pkg::REG_T1CL: model_regs[iatirq_pkg::REG_T1LL] = v;
      iatirq_pkg::REG_T1CH, iatirq_pkg::REG_T1LH: begin
        model_regs[iatirq_pkg::REG_IFR][6] = 1'b0;
        model_regs[iatirq_pkg::REG_T1LH] = v;
        if (r == iatirq_pkg::REG_T1CH) begin
          t1_count = {v, model_regs[iatirq_pkg::REG_T1LL]};
          t1_running = 1'b1;
          pb7_state = 1'b0;
        end
      end
      iatirq_pkg::REG_T2CH: begin
        model_regs[iatirq_pkg::REG_IFR][5] = 1'b0;
        t2_count = {v, model_regs[iatirq_pkg::REG_T2CL]};
        t2_running = 1'b1;
      end
      iatirq_pkg::REG_SR: begin
        model_regs[iatirq_pkg::REG_IFR][2] = 1'b0;
        model_regs[iatirq_pkg::REG_SR] = v;
      end
      iatirq_pkg::REG_IFR: begin
        if (v[0] && (pcr & 8'h0a) == 8'h02) model_regs[iatirq_pkg::REG_IFR][0] = 1'b0;
        if (v[3] && (pcr & 8'ha0) == 8'h20) model_regs[iatirq_pkg::REG_IFR][3] = 1'b0;
      end
      iatirq_pkg::REG_IER: begin
        if (v[7]) model_regs[iatirq_pkg::REG_IER] = model_regs[iatirq_pkg::REG_IER] | (v & 8'h7f);
        else model_regs[iatirq_pkg::REG_IER] = model_regs[iatirq_pkg::REG_IER] & (~v & 8'h7f);
      end
      default: model_regs[r] = v;
    endcase
  endfunction

  function automatic void model_tick(input int unsigned nclk, input int unsigned npulse);
    logic [7:0]  acr;
    logic [7:0]  ifr;
    int unsigned cnt;
    int unsigned left;
    int unsigned used;
    int unsigned latch;
    int unsigned t2n;
    acr = model_regs[iatirq_pkg::REG_ACR];
    ifr = model_regs[iatirq_pkg::REG_IFR];
    cnt = t1_count;
    left = nclk;
    while (left > 0) begin
      latch = {model_regs[iatirq_pkg::REG_T1LH], model_regs[iatirq_pkg::REG_T1LL]};
      if (t1_reload_due) begin
        used = latch + 1;
        if (left < used) used = left;
        cnt = latch + 1 - used;
        t1_reload_due = 1'b0;
      end else if (cnt < left) begin
        if (t1_running) begin
          ifr[6] = 1'b1;
          pb7_state = ~pb7_state;
          if (!acr[6]) t1_running = 1'b0;
        end
        if (left - cnt == 1) begin
          cnt = 16'hffff;
          t1_reload_due = 1'b1;
          used = 1;
        end else begin
          used = cnt + latch + 2;
          if (left < used) used = left;
          cnt = cnt + latch + 2 - used;
        end
      end else begin
        cnt -= left;
        break;
      end
      left -= used;
    end
    t1_count = cnt[15:0];
    t2n = acr[5] ? npulse : nclk;
    if (t2_count < t2n) begin
      if (t2_running) begin
        ifr[5] = 1'b1;
        t2_running = 1'b0;
      end
      t2_count = 16'(32'h10000 + t2_count - t2n);
    end else begin
      t2_count = 16'(t2_count - t2n);
    end
    model_regs[iatirq_pkg::REG_IFR] = ifr;
  endfunction

  function automatic response_t model_predict(input request_t rq);
    response_t rs;
    int unsigned nclk;
    nclk = rq.clocks;
    if (nclk > TICK_LIMIT) nclk = TICK_LIMIT;
    rs.rdata = 8'h00;
    case (rq.action)
      iatirq_pkg::ACT_READ:  rs.rdata = model_read(rq.regn, rq.peek);
      iatirq_pkg::ACT_WRITE: model_write(rq.regn, rq.wdata);
      iatirq_pkg::ACT_TICK:  model_tick(nclk, rq.pulses);
      default: ;
    endcase
    rs.irq = (model_regs[iatirq_pkg::REG_IFR] & model_regs[iatirq_pkg::REG_IER]) != 0;
    rs.pb7 = pb7_state;
    return rs;
  endfunction

  task automatic send_request(input request_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= rq.action;
    in_reg_index <= rq.regn;
    in_write_data <= rq.wdata;
    in_peek <= rq.peek;
    in_clocks <= rq.clocks;
    in_pb6_pulses <= rq.pulses;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue(input request_t rq, input logic known, input response_t want);
    response_t rs;
    rs = model_predict(rq);
    if (known && rs != want)
      report_mismatch("directed row vs model", int'(rs), int'(want));
    expected_responses.push_back(known ? want : rs);
    send_request(rq);
  endtask

  function automatic request_t mk(input logic [1:0] a, input logic [3:0] r,
                                  input logic [7:0] w, input logic pk,
                                  input logic [7:0] c, input logic [7:0] p);
    request_t rq;
    rq.action = a; rq.regn = r; rq.wdata = w; rq.peek = pk;
    rq.clocks = c; rq.pulses = p;
    return rq;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int unsigned pick;
    rq = request_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 35) begin
      rq.action = iatirq_pkg::ACT_TICK;
      if ($urandom_range(3) != 0) rq.clocks = 8'($urandom_range(12));
      if ($urandom_range(3) != 0) rq.pulses = 8'($urandom_range(6));
    end else if (pick < 65) begin
      rq.action = iatirq_pkg::ACT_WRITE;
      if ($urandom_range(2) == 0)
        rq.regn = $urandom_range(1) ? iatirq_pkg::REG_T1CH : iatirq_pkg::REG_T2CH;
      if (rq.regn inside {iatirq_pkg::REG_T1CL, iatirq_pkg::REG_T1CH, iatirq_pkg::REG_T1LL,
                          iatirq_pkg::REG_T1LH, iatirq_pkg::REG_T2CL, iatirq_pkg::REG_T2CH}
          && $urandom_range(1)) rq.wdata = 8'($urandom_range(8));
    end else if (pick < 97) begin
      rq.action = iatirq_pkg::ACT_READ;
    end else begin
      rq.action = ACT_NONE;
    end
    return rq;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected response", out_read_data, 0);
        end else begin
          want = expected_responses.pop_front();
          if (out_read_data !== want.rdata)
            report_mismatch("read_data", out_read_data, want.rdata);
          if (out_irq !== want.irq) report_mismatch("irq", out_irq, want.irq);
          if (out_pb7_level !== want.pb7)
            report_mismatch("pb7_level", out_pb7_level, want.pb7);
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = iatirq_pkg::ACT_READ;
    in_reg_index = iatirq_pkg::REG_ORB;
    in_write_data = 8'h00;
    in_peek = 1'b0;
    in_clocks = 8'h00;
    in_pb6_pulses = 8'h00;
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_IER,  8'h00, 1'b0, 8'h00, 8'h00),
        1'b1, '{8'h80, 1'b0, 1'b1}},
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_T1CH, 8'h00, 1'b0, 8'h00, 8'h00),
        1'b1, '{8'h00, 1'b0, 1'b1}},
      '{mk(ACT_NONE,              iatirq_pkg::REG_ORAN, 8'hff, 1'b1, 8'hff, 8'hff),
        1'b1, '{8'h00, 1'b0, 1'b1}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_ORAN, 8'hff, 1'b0, 8'h00, 8'h00),
        1'b1, '{8'h00, 1'b0, 1'b1}},
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_ORA,  8'h00, 1'b0, 8'h00, 8'h00),
        1'b1, '{8'hff, 1'b0, 1'b1}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_IER,  8'hff, 1'b0, 8'h00, 8'h00),
        1'b1, '{8'h00, 1'b0, 1'b1}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_IER,  8'h1f, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_ACR,  8'h40, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_T1CL, 8'h03, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_T1CH, 8'h00, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_TICK,  iatirq_pkg::REG_ORB,  8'h00, 1'b0, 8'hff, 8'hff),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_IFR,  8'h00, 1'b1, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_T1CL, 8'h00, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_T2CL, 8'h02, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_T2CH, 8'h00, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_TICK,  iatirq_pkg::REG_ORB,  8'h01, 1'b0, 8'h05, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_T2CL, 8'h00, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_T2CH, 8'h00, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_ACR,  8'h20, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_T2CH, 8'h00, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_TICK,  iatirq_pkg::REG_ORB,  8'h00, 1'b0, 8'h40, 8'h03),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_PCR,  8'h22, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_WRITE, iatirq_pkg::REG_IFR,  8'hff, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_IER,  8'h00, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}},
      '{mk(iatirq_pkg::ACT_READ,  iatirq_pkg::REG_SR,   8'h00, 1'b0, 8'h00, 8'h00),
        1'b0, '{8'h00, 1'b0, 1'b0}}
    };
    foreach (rows[i]) begin
      rw = rows[i];
      issue(rw.req, rw.known, rw.rsp);
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 10 : 0;
      for (int n = 0; n < 260; n++) begin
        issue(random_request(), 1'b0, '0);
        if (n == 130) drain();
      end
      drain();
    end

    if (error_count == 0) begin
      $display("interface_adapter_timers_irq_core_test: done, clean");
    end else begin
      $display("interface_adapter_timers_irq_core_test: done, errors");
    end
    $finish;
  end

endmodule
